// ----- rtl/core/pmseq_pkg.sv -----
// Shared types and constants for the power mode sequencer.
// Holds the mode encoding, register indexes and the request and result structs.
// No dependencies.
package pmseq_pkg;

  // Operating modes, encoded as reported on the result channel.
  typedef enum logic [2:0] {
    MODE_PRESAMPLE = 3'd0,
    MODE_NORMAL    = 3'd1,
    MODE_PRESLEEP  = 3'd2,
    MODE_SLEEP     = 3'd3,
    MODE_STANDBY   = 3'd4
  } pmseq_mode_e;

  // Configuration register indexes.
  localparam int unsigned CfgIdxW = 2;
  localparam int unsigned CfgDataW = 16;

  typedef enum logic [CfgIdxW-1:0] {
    CFG_PRESAMPLE_TICKS   = 2'd0,
    CFG_NORMAL_HOLD_TICKS = 2'd1,
    CFG_PRESLEEP_TICKS    = 2'd2,
    CFG_SLEEP_TICKS       = 2'd3
  } pmseq_cfg_idx_e;

  // Register reset values.
  localparam logic [CfgDataW-1:0] PresampleTicksRst  = 16'd5;
  localparam logic [CfgDataW-1:0] NormalHoldTicksRst = 16'd100;
  localparam logic [CfgDataW-1:0] PresleepTicksRst   = 16'd10;
  localparam logic [CfgDataW-1:0] SleepTicksRst      = 16'd500;

  // Pre-sleep code that asks for sleep.
  localparam logic [7:0] SleepRequestCode = 8'h03;

  // One tick request.
  typedef struct packed {
    logic       ignition_on;
    logic [7:0] presleep_code;
  } pmseq_in_t;

  // One tick result.
  typedef struct packed {
    logic [2:0] mode;
    logic       rails_on;
    logic       mode_entered;
    logic       clear_presleep;
    logic       wake_reinit;
  } pmseq_out_t;

  // Event pulses produced by one step.
  typedef struct packed {
    logic mode_entered;
    logic clear_presleep;
    logic wake_reinit;
  } pmseq_flags_t;

  // Per-mode reload values as held in the configuration registers.
  typedef struct packed {
    logic [CfgDataW-1:0] presample_ticks;
    logic [CfgDataW-1:0] normal_hold_ticks;
    logic [CfgDataW-1:0] presleep_ticks;
    logic [CfgDataW-1:0] sleep_ticks;
  } pmseq_cfg_t;

endpackage

// ----- rtl/core/pmseq_step.sv -----
// Next-state logic of the power mode sequencer for one tick.
// Pure combinational; uses pmseq_pkg for the mode enum and structs.
module pmseq_step #(
  parameter int unsigned COUNT_WIDTH = 16
) (
  input  pmseq_pkg::pmseq_mode_e  mode_i,
  input  logic [COUNT_WIDTH-1:0]  cnt_i,
  input  logic                    rails_i,
  input  pmseq_pkg::pmseq_cfg_t   cfg_i,
  input  pmseq_pkg::pmseq_in_t    req_i,
  output pmseq_pkg::pmseq_mode_e  mode_o,
  output logic [COUNT_WIDTH-1:0]  cnt_o,
  output logic                    rails_o,
  output pmseq_pkg::pmseq_flags_t flags_o
);

  logic [COUNT_WIDTH-1:0] cnt_dec;
  logic                   cnt_zero;
  logic                   dec_zero;
  logic                   sleep_req;
  logic [COUNT_WIDTH-1:0] load_presample;
  logic [COUNT_WIDTH-1:0] load_normal;
  logic [COUNT_WIDTH-1:0] load_presleep;
  logic [COUNT_WIDTH-1:0] load_sleep;

  // Shared decrement and zero tests; reload values cut or widened to the counter.
  assign cnt_dec        = cnt_i - COUNT_WIDTH'(1);
  assign cnt_zero       = (cnt_i == '0);
  assign dec_zero       = (cnt_dec == '0);
  assign sleep_req      = (req_i.presleep_code == pmseq_pkg::SleepRequestCode) &&
                          !req_i.ignition_on;
  assign load_presample = COUNT_WIDTH'(cfg_i.presample_ticks);
  assign load_normal    = COUNT_WIDTH'(cfg_i.normal_hold_ticks);
  assign load_presleep  = COUNT_WIDTH'(cfg_i.presleep_ticks);
  assign load_sleep     = COUNT_WIDTH'(cfg_i.sleep_ticks);

  // Next mode, counter and rail level.
  always_comb begin
    mode_o  = mode_i;
    cnt_o   = cnt_i;
    rails_o = rails_i;
    unique case (mode_i)
      pmseq_pkg::MODE_PRESAMPLE: begin
        if (!cnt_zero) begin
          cnt_o = cnt_dec;
          if (dec_zero) begin
            if (req_i.ignition_on) begin
              rails_o = 1'b1;
            end
            mode_o = pmseq_pkg::MODE_NORMAL;
            cnt_o  = load_normal;
          end
        end
      end
      pmseq_pkg::MODE_NORMAL: begin
        if (sleep_req) begin
          cnt_o = cnt_dec;
          if (dec_zero) begin
            mode_o = pmseq_pkg::MODE_PRESLEEP;
            cnt_o  = load_presleep;
          end
        end else begin
          cnt_o = load_normal;
        end
      end
      pmseq_pkg::MODE_PRESLEEP: begin
        // A zero counter stays zero, so it times out at once.
        if (cnt_zero || dec_zero) begin
          rails_o = 1'b0;
          mode_o  = pmseq_pkg::MODE_SLEEP;
          cnt_o   = load_sleep;
        end else begin
          cnt_o = cnt_dec;
        end
      end
      pmseq_pkg::MODE_SLEEP: begin
        if (req_i.ignition_on) begin
          mode_o = pmseq_pkg::MODE_PRESAMPLE;
          cnt_o  = load_presample;
        end else if (!cnt_zero) begin
          // Standby keeps the counter as it is, which is zero here.
          cnt_o = cnt_dec;
          if (dec_zero) begin
            mode_o = pmseq_pkg::MODE_STANDBY;
          end
        end
      end
      pmseq_pkg::MODE_STANDBY: begin
        if (req_i.ignition_on) begin
          mode_o = pmseq_pkg::MODE_PRESAMPLE;
          cnt_o  = load_presample;
        end
      end
      default: begin
        // Unused mode codes hold all state.
      end
    endcase
  end

  // Event pulses: every entry is a change of mode.
  always_comb begin
    flags_o.mode_entered   = (mode_o != mode_i);
    flags_o.clear_presleep = (mode_i == pmseq_pkg::MODE_NORMAL) &&
                             (mode_o == pmseq_pkg::MODE_PRESLEEP);
    flags_o.wake_reinit    = ((mode_i == pmseq_pkg::MODE_SLEEP) ||
                              (mode_i == pmseq_pkg::MODE_STANDBY)) &&
                             (mode_o == pmseq_pkg::MODE_PRESAMPLE);
  end

endmodule

// ----- rtl/core/power_mode_sequencer.sv -----
// Power mode sequencer: a result is offered in the cycle after its request is taken.
// Throughput is one request per cycle; the result register frees itself in the same
// cycle it is taken, so requests stall only while a result is held back downstream.
// The mode, counter and rail state update in the accepting cycle, so the next request
// sees them at once. Asynchronous active-low reset returns to presample with the
// presample reload count, rails off, no result valid and config at reset values.
module power_mode_sequencer #(
  parameter int unsigned COUNT_WIDTH = 16
) (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                in_valid_i,
  output logic                                in_stall_o,
  input  pmseq_pkg::pmseq_in_t                in_data_i,
  output logic                                out_valid_o,
  input  logic                                out_stall_i,
  output pmseq_pkg::pmseq_out_t               out_data_o,
  input  logic                                cfg_valid_i,
  output logic                                cfg_ready_o,
  input  logic [pmseq_pkg::CfgIdxW-1:0]       cfg_idx_i,
  input  logic [pmseq_pkg::CfgDataW-1:0]      cfg_data_i
);

  pmseq_pkg::pmseq_cfg_t   cfg_q;
  pmseq_pkg::pmseq_mode_e  mode_q;
  pmseq_pkg::pmseq_mode_e  mode_d;
  logic [COUNT_WIDTH-1:0]  cnt_q;
  logic [COUNT_WIDTH-1:0]  cnt_d;
  logic                    rails_q;
  logic                    rails_d;
  pmseq_pkg::pmseq_flags_t flags;
  logic                    out_valid_q;
  logic                    out_valid_d;
  pmseq_pkg::pmseq_out_t   out_data_q;
  logic                    accept;

  // Handshake: a held result only blocks while the downstream stalls.
  assign in_stall_o  = out_valid_q && out_stall_i;
  assign accept      = in_valid_i && !in_stall_o;
  assign cfg_ready_o = 1'b1;

  // Configuration registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.presample_ticks   <= pmseq_pkg::PresampleTicksRst;
      cfg_q.normal_hold_ticks <= pmseq_pkg::NormalHoldTicksRst;
      cfg_q.presleep_ticks    <= pmseq_pkg::PresleepTicksRst;
      cfg_q.sleep_ticks       <= pmseq_pkg::SleepTicksRst;
    end else if (cfg_valid_i && cfg_ready_o) begin
      unique case (pmseq_pkg::pmseq_cfg_idx_e'(cfg_idx_i))
        pmseq_pkg::CFG_PRESAMPLE_TICKS:   cfg_q.presample_ticks   <= cfg_data_i;
        pmseq_pkg::CFG_NORMAL_HOLD_TICKS: cfg_q.normal_hold_ticks <= cfg_data_i;
        pmseq_pkg::CFG_PRESLEEP_TICKS:    cfg_q.presleep_ticks    <= cfg_data_i;
        pmseq_pkg::CFG_SLEEP_TICKS:       cfg_q.sleep_ticks       <= cfg_data_i;
        default: begin
        end
      endcase
    end
  end

  // Mode step for the request on the input.
  pmseq_step #(
    .COUNT_WIDTH(COUNT_WIDTH)
  ) u_step (
    .mode_i  (mode_q),
    .cnt_i   (cnt_q),
    .rails_i (rails_q),
    .cfg_i   (cfg_q),
    .req_i   (in_data_i),
    .mode_o  (mode_d),
    .cnt_o   (cnt_d),
    .rails_o (rails_d),
    .flags_o (flags)
  );

  // Sequencer state advances once per accepted request.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q  <= pmseq_pkg::MODE_PRESAMPLE;
      cnt_q   <= COUNT_WIDTH'(pmseq_pkg::PresampleTicksRst);
      rails_q <= 1'b0;
    end else if (accept) begin
      mode_q  <= mode_d;
      cnt_q   <= cnt_d;
      rails_q <= rails_d;
    end
  end

  // Result register valid flag.
  always_comb begin
    if (accept) begin
      out_valid_d = 1'b1;
    end else if (out_stall_i) begin
      out_valid_d = out_valid_q;
    end else begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else begin
      out_valid_q <= out_valid_d;
    end
  end

  // Result payload, loaded with the state after the tick.
  always_ff @(posedge clk_i) begin
    if (accept) begin
      out_data_q.mode           <= mode_d;
      out_data_q.rails_on       <= rails_d;
      out_data_q.mode_entered   <= flags.mode_entered;
      out_data_q.clear_presleep <= flags.clear_presleep;
      out_data_q.wake_reinit    <= flags.wake_reinit;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_data_q;

endmodule

// ----- rtl/core/pmseq_checker.sv -----
// Port-level checks for the power mode sequencer, bound to the top level.
// Uses pmseq_pkg for the mode encoding and the payload structs.
module pmseq_checker (
  input logic                  clk_i,
  input logic                  rst_ni,
  input logic                  out_valid_o,
  input logic                  out_stall_i,
  input pmseq_pkg::pmseq_out_t out_data_o
);

  // A stalled result stays offered and unchanged.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o && $stable(out_data_o))
    else $error("stalled result dropped or changed");

  // A wake always lands in presample as a fresh entry.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_data_o.wake_reinit |->
      out_data_o.mode == pmseq_pkg::MODE_PRESAMPLE && out_data_o.mode_entered)
    else $error("wake pulse without entry to presample");

  // The clear request only comes with the entry to presleep.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_data_o.clear_presleep |->
      out_data_o.mode == pmseq_pkg::MODE_PRESLEEP && out_data_o.mode_entered &&
      !out_data_o.wake_reinit)
    else $error("clear pulse without entry to presleep");

  // Rails are always off in sleep and standby.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && (out_data_o.mode == pmseq_pkg::MODE_SLEEP ||
                    out_data_o.mode == pmseq_pkg::MODE_STANDBY) |->
      !out_data_o.rails_on)
    else $error("rails on while asleep");

endmodule

bind power_mode_sequencer pmseq_checker u_pmseq_checker (.*);

// ----- sim/pmseq_tb_pkg.sv -----
// Tracking model of the power mode sequencer, used by the testbench in tb.sv.
// Predicts the result of every accepted tick request and checks results in order.
// Depends on pmseq_pkg.
package pmseq_tb_pkg;
  import pmseq_pkg::*;

  class power_mode_tracker;
    pmseq_cfg_t           reload;
    pmseq_mode_e          mode;
    logic [CfgDataW-1:0]  count;
    logic                 rails;
    pmseq_out_t           due_results[$];
    int unsigned          mismatches;
    int unsigned          results_seen;

    // Start from the state the block holds after reset.
    function new();
      reload.presample_ticks   = PresampleTicksRst;
      reload.normal_hold_ticks = NormalHoldTicksRst;
      reload.presleep_ticks    = PresleepTicksRst;
      reload.sleep_ticks       = SleepTicksRst;
      mode         = MODE_PRESAMPLE;
      count        = PresampleTicksRst;
      rails        = 1'b0;
      mismatches   = 0;
      results_seen = 0;
    endfunction

    function void write_reg(pmseq_cfg_idx_e idx, logic [CfgDataW-1:0] value);
      case (idx)
        CFG_PRESAMPLE_TICKS:   reload.presample_ticks   = value;
        CFG_NORMAL_HOLD_TICKS: reload.normal_hold_ticks = value;
        CFG_PRESLEEP_TICKS:    reload.presleep_ticks    = value;
        CFG_SLEEP_TICKS:       reload.sleep_ticks       = value;
        default: ;
      endcase
    endfunction

    // Enter a mode and load its reload count; standby leaves the counter alone.
    // Returns the mode-entered pulse.
    function logic load_mode(pmseq_mode_e next);
      mode = next;
      case (next)
        MODE_PRESAMPLE: count = reload.presample_ticks;
        MODE_NORMAL:    count = reload.normal_hold_ticks;
        MODE_PRESLEEP:  count = reload.presleep_ticks;
        MODE_SLEEP:     count = reload.sleep_ticks;
        default: ;
      endcase
      return 1'b1;
    endfunction

    // Advance the mode machine by one tick and queue the result it gives.
    function void take_request(pmseq_in_t req);
      pmseq_out_t res;
      res = '0;
      case (mode)
        MODE_PRESAMPLE: begin
          // A zero reload leaves the counter at zero, so presample never ends.
          if (count != 0) begin
            count = count - 1'b1;
            if (count == 0) begin
              if (req.ignition_on) rails = 1'b1;
              res.mode_entered = load_mode(MODE_NORMAL);
            end
          end
        end
        MODE_NORMAL: begin
          // The count is not tested first, so a zero reload wraps to all ones.
          if (req.presleep_code == SleepRequestCode && !req.ignition_on) begin
            count = count - 1'b1;
            if (count == 0) begin
              res.clear_presleep = 1'b1;
              res.mode_entered   = load_mode(MODE_PRESLEEP);
            end
          end else begin
            count = reload.normal_hold_ticks;
          end
        end
        MODE_PRESLEEP: begin
          if (count != 0) count = count - 1'b1;
          if (count == 0) begin
            rails = 1'b0;
            res.mode_entered = load_mode(MODE_SLEEP);
          end
        end
        MODE_SLEEP: begin
          // A zero reload means sleep lasts until the ignition comes on.
          if (req.ignition_on) begin
            res.wake_reinit  = 1'b1;
            res.mode_entered = load_mode(MODE_PRESAMPLE);
          end else if (count != 0) begin
            count = count - 1'b1;
            if (count == 0) res.mode_entered = load_mode(MODE_STANDBY);
          end
        end
        MODE_STANDBY: begin
          if (req.ignition_on) begin
            res.wake_reinit  = 1'b1;
            res.mode_entered = load_mode(MODE_PRESAMPLE);
          end
        end
        default: ;
      endcase
      res.mode     = mode;
      res.rails_on = rails;
      due_results.push_back(res);
    endfunction

    task report(string msg);
      mismatches++;
      if (mismatches <= 40) $display("MISMATCH: %s", msg);
    endtask

    // Compare a delivered result with the oldest prediction, field by field.
    task take_result(pmseq_out_t got);
      pmseq_out_t want;
      results_seen++;
      if (due_results.size() == 0) begin
        report($sformatf("result %0d arrived with no request outstanding", results_seen));
      end else begin
        want = due_results.pop_front();
        if (got.mode !== want.mode)
          report($sformatf("result %0d: mode %0d, expected %0d",
                           results_seen, got.mode, want.mode));
        if (got.rails_on !== want.rails_on)
          report($sformatf("result %0d: rails_on %b, expected %b",
                           results_seen, got.rails_on, want.rails_on));
        if (got.mode_entered !== want.mode_entered)
          report($sformatf("result %0d: mode_entered %b, expected %b",
                           results_seen, got.mode_entered, want.mode_entered));
        if (got.clear_presleep !== want.clear_presleep)
          report($sformatf("result %0d: clear_presleep %b, expected %b",
                           results_seen, got.clear_presleep, want.clear_presleep));
        if (got.wake_reinit !== want.wake_reinit)
          report($sformatf("result %0d: wake_reinit %b, expected %b",
                           results_seen, got.wake_reinit, want.wake_reinit));
      end
    endtask
  endclass

endpackage

// ----- sim/tb.sv -----
// Testbench top for the power mode sequencer: directed ticks, then random phases
// under several register settings, with idling and back-pressure on both sides.
// Depends on pmseq_pkg, pmseq_tb_pkg and power_mode_sequencer.
module tb;
  timeunit 1ns;
  timeprecision 1ps;

  import pmseq_pkg::*;
  import pmseq_tb_pkg::*;

  localparam int unsigned QuietLimit = 4000;
  localparam int unsigned LongHold   = 200;

  logic                clk       = 1'b0;
  logic                rst_n     = 1'b0;
  logic                in_valid  = 1'b0;
  pmseq_in_t           in_data   = '0;
  logic                in_stall;
  logic                out_valid;
  logic                out_stall = 1'b0;
  pmseq_out_t          out_data;
  logic                cfg_valid = 1'b0;
  pmseq_cfg_idx_e      cfg_idx   = CFG_PRESAMPLE_TICKS;
  logic [CfgDataW-1:0] cfg_data  = '0;
  logic                cfg_ready;

  power_mode_tracker sb;

  int unsigned send_idle_pct  = 0;
  int unsigned recv_stall_pct = 0;
  int unsigned hold_asked     = 0;
  int unsigned hold_served    = 0;
  int unsigned hold_left      = 0;
  int unsigned quiet_cycles   = 0;

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  power_mode_sequencer u_dut (
    .clk_i       (clk),
    .rst_ni      (rst_n),
    .in_valid_i  (in_valid),
    .in_stall_o  (in_stall),
    .in_data_i   (in_data),
    .out_valid_o (out_valid),
    .out_stall_i (out_stall),
    .out_data_o  (out_data),
    .cfg_valid_i (cfg_valid),
    .cfg_ready_o (cfg_ready),
    .cfg_idx_i   (cfg_idx),
    .cfg_data_i  (cfg_data)
  );

  // Receiver: random stalls, or a long hold-off when one is asked for.
  always @(posedge clk) begin
    if (hold_asked != hold_served) begin
      hold_served <= hold_asked;
      hold_left   <= LongHold;
      out_stall   <= 1'b1;
    end else if (hold_left != 0) begin
      hold_left <= hold_left - 1;
      out_stall <= 1'b1;
    end else begin
      out_stall <= ($urandom_range(99) < recv_stall_pct);
    end
  end

  // Every delivered result is checked against the tracker.
  always @(posedge clk) begin
    if (out_valid && !out_stall) sb.take_result(out_data);
  end

  // Give up if no channel has moved anything for too long.
  always @(posedge clk) begin
    if ((in_valid && !in_stall) || (out_valid && !out_stall) || (cfg_valid && cfg_ready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles == QuietLimit) begin
      $display("CHECKS FAILED");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  // Offer one request, after a random gap, and wait until it is taken.
  // Valid stays high afterwards so that back-to-back requests need no toggle.
  task automatic send_request(pmseq_in_t req);
    if ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      do @(posedge clk); while ($urandom_range(99) < send_idle_pct);
    end
    in_valid <= 1'b1;
    in_data  <= req;
    do @(posedge clk); while (in_stall);
    sb.take_request(req);
  endtask

  task automatic send_tick(logic ign, logic [7:0] code);
    pmseq_in_t req;
    req.ignition_on   = ign;
    req.presleep_code = code;
    send_request(req);
  endtask

  // Mostly well-formed requests for the current mode, with some noise mixed in.
  // With park set, presleep, presample and wake are avoided so that maximum
  // reload counts never have to be waited out.
  function automatic pmseq_in_t make_request(bit park);
    pmseq_in_t req;
    bit        shaped;
    req.ignition_on   = 1'($urandom_range(1));
    req.presleep_code = 8'($urandom_range(255));
    shaped            = ($urandom_range(99) >= 12);
    case (sb.mode)
      MODE_NORMAL: begin
        if (shaped) begin
          req.presleep_code = SleepRequestCode;
          req.ignition_on   = ($urandom_range(99) < 4);
        end
        if (park && sb.count <= 1) req.ignition_on = 1'b1;
      end
      MODE_SLEEP, MODE_STANDBY: begin
        if (shaped) req.ignition_on = ($urandom_range(99) < 15);
        if (park) req.ignition_on = 1'b0;
      end
      default: ;
    endcase
    return req;
  endfunction

  task automatic run_random(int unsigned n, bit park);
    repeat (n) send_request(make_request(park));
  endtask

  // Stop offering and wait until every predicted result has been delivered.
  task automatic drain();
    in_valid <= 1'b0;
    do @(posedge clk); while (sb.due_results.size() != 0);
  endtask

  task automatic write_reg(pmseq_cfg_idx_e idx, logic [CfgDataW-1:0] value);
    cfg_valid <= 1'b1;
    cfg_idx   <= idx;
    cfg_data  <= value;
    do @(posedge clk); while (!cfg_ready);
    sb.write_reg(idx, value);
  endtask

  task automatic write_config(logic [CfgDataW-1:0] presample_ticks, normal_hold_ticks,
                              presleep_ticks, sleep_ticks);
    write_reg(CFG_PRESAMPLE_TICKS, presample_ticks);
    write_reg(CFG_NORMAL_HOLD_TICKS, normal_hold_ticks);
    write_reg(CFG_PRESLEEP_TICKS, presleep_ticks);
    write_reg(CFG_SLEEP_TICKS, sleep_ticks);
    cfg_valid <= 1'b0;
  endtask

  initial begin
    int unsigned stuck;
    int unsigned sent;
    sb = new();
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;

    send_idle_pct  = 30;
    recv_stall_pct = 45;
    write_config(16'd2, 16'd3, 16'd2, 16'd3);

    // Presample still runs on the reset count of five; rails come on at its end.
    send_tick(1'b1, 8'hFF);
    send_tick(1'b0, 8'h00);
    send_tick(1'b1, SleepRequestCode);
    send_tick(1'b0, 8'h80);
    send_tick(1'b1, 8'h7F);
    // Normal: the request is broken by ignition and by another code, then held.
    send_tick(1'b0, SleepRequestCode);
    send_tick(1'b1, SleepRequestCode);
    send_tick(1'b0, 8'h02);
    send_tick(1'b0, SleepRequestCode);
    send_tick(1'b0, SleepRequestCode);
    send_tick(1'b0, SleepRequestCode);
    // Presleep runs out, rails go off, then sleep times out into standby.
    send_tick(1'b1, 8'hAA);
    send_tick(1'b0, 8'h55);
    send_tick(1'b0, SleepRequestCode);
    send_tick(1'b0, 8'hFF);
    send_tick(1'b0, 8'h00);
    send_tick(1'b0, SleepRequestCode);
    // Wake from standby; presample ends with ignition off, so the rails stay off.
    send_tick(1'b1, 8'h00);
    send_tick(1'b0, 8'h01);
    send_tick(1'b0, 8'hFE);
    send_tick(1'b0, SleepRequestCode);
    send_tick(1'b0, SleepRequestCode);
    send_tick(1'b0, SleepRequestCode);
    send_tick(1'b0, 8'h00);
    send_tick(1'b0, 8'h00);
    // Wake straight from sleep.
    send_tick(1'b1, 8'hC3);
    drain();

    write_config(16'($urandom_range(1, 6)), 16'($urandom_range(1, 6)),
                 16'($urandom_range(1, 6)), 16'($urandom_range(1, 6)));
    run_random(450, 1'b0);
    drain();

    // Zero presleep and sleep reloads: presleep ends at once, sleep waits for ignition.
    send_idle_pct  = 45;
    recv_stall_pct = 30;
    write_config(16'd1, 16'd1, 16'd0, 16'd0);
    run_random(250, 1'b0);
    drain();

    // Zero normal hold: the counter wraps to all ones on the first held tick.
    write_config(16'd1, 16'd0, 16'd1, 16'd2);
    run_random(200, 1'b0);
    drain();

    // Largest reloads, kept in normal, sleep or standby.
    send_idle_pct  = 0;
    recv_stall_pct = 0;
    write_config(16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF);
    run_random(200, 1'b1);
    drain();

    // Small reloads again, with a long hold-off downstream while requests keep
    // coming, then a pause until every result is in.
    write_config(16'($urandom_range(1, 4)), 16'($urandom_range(1, 4)),
                 16'($urandom_range(1, 4)), 16'($urandom_range(1, 4)));
    run_random(150, 1'b0);
    hold_asked <= hold_asked + 1;
    run_random(40, 1'b0);
    drain();
    run_random(260, 1'b0);
    drain();

    // Zero presample reload: after the next wake the block stays in presample.
    write_config(16'd0, 16'd1, 16'd1, 16'd2);
    stuck = 0;
    sent  = 0;
    while (stuck < 15 && sent < 400) begin
      send_request(make_request(1'b0));
      sent++;
      if (sb.mode == MODE_PRESAMPLE && sb.count == 0) stuck++;
    end
    drain();
    repeat (3) @(posedge clk);

    if (sb.mismatches == 0 && sb.due_results.size() == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule

// ----- files.f -----
rtl/core/pmseq_pkg.sv
rtl/core/pmseq_step.sv
rtl/core/power_mode_sequencer.sv
rtl/core/pmseq_checker.sv
sim/pmseq_tb_pkg.sv
sim/tb.sv
